/* design/rtc3w_pkg.sv */
// Shared types and constants for the three-wire RTC byte master.
package rtc3w_pkg;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
   localparam logic [7:0]  CMD_BASE          = 8'h80;
   localparam logic [4:0]  TOTAL_BITS        = 5'd16;
   localparam logic [4:0]  DATA_FIRST_BIT    = 5'd8;
   localparam logic [4:0]  CMD_LAST_BIT      = 5'd7;

   localparam logic OPCODE_READ  = 1'b0;
   localparam logic OPCODE_WRITE = 1'b1;

   // One result beat: pin levels for this tick plus status.
   typedef struct packed {
      logic       chip_enable;
      logic       serial_clock;
      logic       io_out;
      logic       io_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
   } result_type;

endpackage

/* design/rtc3w_core.sv */
// Transaction state and per-tick sequencing of CE, SCLK and IO.
module rtc3w_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    start_req,
   input  logic                    opcode,
   input  logic [5:0]              reg_address,
   input  logic [7:0]              write_byte,
   input  logic                    io_in,
   input  logic [15:0]             half_period_ticks,
   output rtc3w_pkg::result_type   result
);

   logic        active_ff,     active_in;
   logic        is_read_ff,    is_read_in;
   logic [4:0]  bit_count_ff,  bit_count_in;
   logic [7:0]  out_shift_ff,  out_shift_in;
   logic [7:0]  data_hold_ff,  data_hold_in;
   logic [7:0]  in_shift_ff,   in_shift_in;
   logic [15:0] tick_timer_ff, tick_timer_in;
   logic        clock_high_ff, clock_high_in;

   logic [15:0] half;
   logic [16:0] timer_next;
   logic        phase_end;
   logic        reading_data;
   logic        drive;
   logic        done;

   always_comb begin
      half         = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
      timer_next   = {1'b0, tick_timer_ff} + 17'd1;
      phase_end    = timer_next >= {1'b0, half};
      reading_data = is_read_ff && (bit_count_ff >= rtc3w_pkg::DATA_FIRST_BIT);
      drive        = active_ff && !reading_data;

      active_in     = active_ff;
      is_read_in    = is_read_ff;
      bit_count_in  = bit_count_ff;
      out_shift_in  = out_shift_ff;
      data_hold_in  = data_hold_ff;
      in_shift_in   = in_shift_ff;
      tick_timer_in = tick_timer_ff;
      clock_high_in = clock_high_ff;
      done          = 1'b0;

      if (active_ff) begin
         if (!phase_end) begin
            tick_timer_in = timer_next[15:0];
         end else begin
            tick_timer_in = 16'd0;
            if (clock_high_ff) begin
               // Falling edge: move on to the next bit.
               clock_high_in = 1'b0;
               bit_count_in  = bit_count_ff + 5'd1;
               if (bit_count_ff == rtc3w_pkg::CMD_LAST_BIT) begin
                  out_shift_in = data_hold_ff;
               end else begin
                  out_shift_in = {1'b0, out_shift_ff[7:1]};
               end
            end else if (bit_count_ff >= rtc3w_pkg::TOTAL_BITS) begin
               active_in    = 1'b0;
               bit_count_in = 5'd0;
               done         = 1'b1;
            end else begin
               // Read data is sampled on the last tick before the rising edge.
               if (reading_data) begin
                  in_shift_in = {io_in, in_shift_ff[7:1]};
               end
               clock_high_in = 1'b1;
            end
         end
      end else if (start_req) begin
         active_in     = 1'b1;
         is_read_in    = (opcode == rtc3w_pkg::OPCODE_READ);
         out_shift_in  = rtc3w_pkg::CMD_BASE | {1'b0, reg_address, 1'b0}
                         | {7'd0, (opcode == rtc3w_pkg::OPCODE_READ)};
         data_hold_in  = write_byte;
         bit_count_in  = 5'd0;
         tick_timer_in = 16'd0;
         clock_high_in = 1'b0;
      end

      result.chip_enable  = active_ff;
      result.serial_clock = active_ff && clock_high_ff;
      result.io_out       = drive && out_shift_ff[0];
      result.io_drive     = drive;
      result.busy_res     = active_ff;
      result.done_res     = done;
      result.read_byte    = in_shift_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         is_read_ff    <= 1'b0;
         bit_count_ff  <= 5'd0;
         out_shift_ff  <= 8'd0;
         data_hold_ff  <= 8'd0;
         in_shift_ff   <= 8'd0;
         tick_timer_ff <= 16'd0;
         clock_high_ff <= 1'b0;
      end else if (step) begin
         active_ff     <= active_in;
         is_read_ff    <= is_read_in;
         bit_count_ff  <= bit_count_in;
         out_shift_ff  <= out_shift_in;
         data_hold_ff  <= data_hold_in;
         in_shift_ff   <= in_shift_in;
         tick_timer_ff <= tick_timer_in;
         clock_high_ff <= clock_high_in;
      end
   end

endmodule

/* design/rtc3w_skid.sv */
// Result register with one skid entry, so one more input beat can be taken during a stall.
module rtc3w_skid (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rtc3w_pkg::result_type   push_data,
   output logic                    space,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rtc3w_pkg::result_type   out_data
);

   logic                  out_valid_ff,  out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   rtc3w_pkg::result_type out_data_ff,   out_data_in;
   rtc3w_pkg::result_type skid_data_ff,  skid_data_in;
   logic                  pop;

   always_comb begin
      pop           = out_valid_ff && out_ready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;

      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign space     = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

/* design/three_wire_rtc_byte_master.sv */
// Top level of the three-wire RTC byte master: config register, sequencer and result buffer.
//
// Each request beat is one tick of the serial master and yields exactly one response beat
// carrying the CE, SCLK and IO levels for that tick, plus busy, a one-tick done pulse and
// the byte assembled by the last read. One request beat is taken every clock cycle while req_ready
// is high; its response is registered in the result register for the consumer. A second result
// can be held in the skid entry while the consumer stalls, so req_ready drops only when
// both are full. csr_half_period_ticks sets the SCLK half period in ticks (0 behaves as 1)
// and should be written only while the block is idle.
module three_wire_rtc_byte_master (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_start_req,
   input  logic        req_opcode,
   input  logic [5:0]  req_reg_address,
   input  logic [7:0]  req_write_byte,
   input  logic        req_io_in,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_chip_enable,
   output logic        rsp_serial_clock,
   output logic        rsp_io_out,
   output logic        rsp_io_drive,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_byte,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_half_period_ticks
);

   logic [15:0]           half_ff;
   logic                  step;
   logic                  space;
   rtc3w_pkg::result_type result;
   rtc3w_pkg::result_type rsp_data;

   assign csr_ready = 1'b1;
   assign req_ready = space;
   assign step      = req_valid && space;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= rtc3w_pkg::HALF_PERIOD_RESET;
      end else if (csr_valid) begin
         half_ff <= csr_half_period_ticks;
      end
   end

   rtc3w_core u_core (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .start_req         (req_start_req),
      .opcode            (req_opcode),
      .reg_address       (req_reg_address),
      .write_byte        (req_write_byte),
      .io_in             (req_io_in),
      .half_period_ticks (half_ff),
      .result            (result)
   );

   rtc3w_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (result),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_chip_enable  = rsp_data.chip_enable;
   assign rsp_serial_clock = rsp_data.serial_clock;
   assign rsp_io_out       = rsp_data.io_out;
   assign rsp_io_drive     = rsp_data.io_drive;
   assign rsp_busy_res     = rsp_data.busy_res;
   assign rsp_done_res     = rsp_data.done_res;
   assign rsp_read_byte    = rsp_data.read_byte;

   // A full buffer must hold off the next request beat.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request side ready low with no result waiting");

   // Done is only ever reported on a tick of an active transaction.
   a_done_in_transfer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_chip_enable && !rsp_serial_clock))
      else $error("done reported outside a transaction or with SCLK high");

   // IO is never driven high while released, and SCLK only toggles under CE.
   a_pin_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_io_out || rsp_io_drive) && (!rsp_serial_clock || rsp_chip_enable)))
      else $error("pin levels inconsistent with CE or drive enable");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the three-wire RTC byte master: per-tick pin prediction and checking.
module testbench;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int IO_LOW         = 0;
   localparam int IO_HIGH        = 1;
   localparam int IO_RANDOM      = 2;

   typedef struct packed {
      logic       start_req;
      logic       opcode;
      logic [5:0] reg_address;
      logic [7:0] write_byte;
      logic       io_in;
   } tick_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_start_req;
   logic        req_opcode;
   logic [5:0]  req_reg_address;
   logic [7:0]  req_write_byte;
   logic        req_io_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_chip_enable;
   logic        rsp_serial_clock;
   logic        rsp_io_out;
   logic        rsp_io_drive;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_byte;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_half_period_ticks;

   // Predicted state of the serial master.
   logic [15:0] half_period;
   logic        xfer_active;
   logic        xfer_is_read;
   logic [4:0]  bit_index;
   logic [7:0]  cmd_shift;
   logic [7:0]  data_byte;
   logic [7:0]  sampled_bits;
   logic [15:0] phase_ticks;
   logic        sclk_high;

   rtc3w_pkg::result_type pending_pin_levels[$];
   rtc3w_pkg::result_type wanted;

   int ticks_sent;
   int reads_done;
   int writes_done;
   int settings_used;
   int mismatches;
   int beats_checked;
   int quiet_cycles;
   int hold_request;
   bit sender_gaps;
   bit receiver_stalls;

   three_wire_rtc_byte_master dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_start_req         (req_start_req),
      .req_opcode            (req_opcode),
      .req_reg_address       (req_reg_address),
      .req_write_byte        (req_write_byte),
      .req_io_in             (req_io_in),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_chip_enable       (rsp_chip_enable),
      .rsp_serial_clock      (rsp_serial_clock),
      .rsp_io_out            (rsp_io_out),
      .rsp_io_drive          (rsp_io_drive),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_read_byte         (rsp_read_byte),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_half_period_ticks (csr_half_period_ticks)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Pin levels shown during one tick come from the state before that tick's update.
   function automatic rtc3w_pkg::result_type pin_levels_for_tick(input tick_type t);
      rtc3w_pkg::result_type r;
      logic [16:0]           span;
      logic                  drive;
      span  = (half_period == 16'd0) ? 17'd1 : {1'b0, half_period};
      drive = xfer_active && !(xfer_is_read && bit_index >= rtc3w_pkg::DATA_FIRST_BIT);
      r.chip_enable  = xfer_active;
      r.serial_clock = xfer_active & sclk_high;
      r.io_out       = drive & cmd_shift[0];
      r.io_drive     = drive;
      r.busy_res     = xfer_active;
      r.done_res     = 1'b0;
      if (xfer_active) begin
         if ({1'b0, phase_ticks} + 17'd1 < span) begin
            phase_ticks = phase_ticks + 16'd1;
         end else begin
            phase_ticks = 16'd0;
            if (sclk_high) begin
               sclk_high = 1'b0;
               bit_index = bit_index + 5'd1;
               cmd_shift = cmd_shift >> 1;
               if (bit_index == rtc3w_pkg::DATA_FIRST_BIT)
                  cmd_shift = data_byte;
            end else if (bit_index >= rtc3w_pkg::TOTAL_BITS) begin
               xfer_active = 1'b0;
               bit_index   = 5'd0;
               r.done_res  = 1'b1;
               if (xfer_is_read)
                  reads_done++;
               else
                  writes_done++;
            end else begin
               // A read bit is taken on the last tick before its rising edge.
               if (xfer_is_read && bit_index >= rtc3w_pkg::DATA_FIRST_BIT)
                  sampled_bits = {t.io_in, sampled_bits[7:1]};
               sclk_high = 1'b1;
            end
         end
      end else if (t.start_req) begin
         xfer_active  = 1'b1;
         xfer_is_read = (t.opcode == rtc3w_pkg::OPCODE_READ);
         cmd_shift    = rtc3w_pkg::CMD_BASE | {1'b0, t.reg_address, xfer_is_read};
         data_byte    = t.write_byte;
         bit_index    = 5'd0;
         phase_ticks  = 16'd0;
         sclk_high    = 1'b0;
      end
      r.read_byte = sampled_bits;
      return r;
   endfunction

   function automatic tick_type random_tick();
      tick_type t;
      t.start_req   = 1'($urandom_range(0, 1));
      t.opcode      = 1'($urandom_range(0, 1));
      t.reg_address = 6'($urandom_range(0, 63));
      t.write_byte  = 8'($urandom_range(0, 255));
      t.io_in       = 1'($urandom_range(0, 1));
      return t;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 40)
         $display("response beat %0d: %s is %0d, predicted %0d",
                  beats_checked, what, got, want);
   endtask

   task automatic send_tick(input tick_type t);
      if (sender_gaps && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_start_req   <= t.start_req;
      req_opcode      <= t.opcode;
      req_reg_address <= t.reg_address;
      req_write_byte  <= t.write_byte;
      req_io_in       <= t.io_in;
      do @(posedge clock); while (!req_ready);
      pending_pin_levels.push_back(pin_levels_for_tick(t));
      ticks_sent++;
   endtask

   // Stops offering beats and waits until every predicted response has been seen.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pin_levels.size() != 0);
   endtask

   task automatic set_half_period(input logic [15:0] ticks);
      drain_responses();
      csr_valid             <= 1'b1;
      csr_half_period_ticks <= ticks;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      half_period  = ticks;
      settings_used++;
   endtask

   task automatic finish_transfer();
      while (xfer_active)
         send_tick(random_tick());
   endtask

   task automatic run_transaction(input logic opcode, input logic [5:0] address,
                                  input logic [7:0] wdata, input int io_mode,
                                  input bit keep_start);
      tick_type t;
      t.start_req   = 1'b1;
      t.opcode      = opcode;
      t.reg_address = address;
      t.write_byte  = wdata;
      t.io_in       = 1'b0;
      send_tick(t);
      while (xfer_active) begin
         t = random_tick();
         if (keep_start)
            t.start_req = 1'b1;
         if (io_mode != IO_RANDOM)
            t.io_in = (io_mode == IO_HIGH);
         send_tick(t);
      end
   endtask

   task automatic run_random(input int count);
      repeat (count) send_tick(random_tick());
   endtask

   // A write at the reset half period, shortened part way through.
   task automatic test_reset_half_period();
      tick_type t;
      t = random_tick();
      t.start_req   = 1'b1;
      t.opcode      = rtc3w_pkg::OPCODE_WRITE;
      t.reg_address = 6'd21;
      t.write_byte  = 8'hA5;
      send_tick(t);
      repeat (250) send_tick(random_tick());
      set_half_period(16'd3);
      finish_transfer();
   endtask

   task automatic test_directed_transfers();
      // A zero half period must behave as one tick.
      set_half_period(16'd0);
      run_transaction(rtc3w_pkg::OPCODE_READ, 6'd63, 8'h00, IO_HIGH, 1'b0);
      set_half_period(16'd1);
      run_transaction(rtc3w_pkg::OPCODE_WRITE, 6'd0, 8'hFF, IO_RANDOM, 1'b1);
      run_transaction(rtc3w_pkg::OPCODE_WRITE, 6'd63, 8'h00, IO_RANDOM, 1'b0);
      // Start held high throughout, including on the done tick, where it is ignored.
      run_transaction(rtc3w_pkg::OPCODE_READ, 6'd0, 8'hFF, IO_LOW, 1'b1);
      run_transaction(rtc3w_pkg::OPCODE_READ, 6'd42, 8'h5A, IO_RANDOM, 1'b0);
   endtask

   task automatic test_half_period_changes();
      tick_type t;
      set_half_period(16'hFFFF);
      t = random_tick();
      t.start_req = 1'b1;
      t.opcode    = rtc3w_pkg::OPCODE_READ;
      send_tick(t);
      repeat (40) send_tick(random_tick());
      // The timer is already past the new value, so the phase ends on the next tick.
      set_half_period(16'd1);
      finish_transfer();
      set_half_period(16'd2);
      t = random_tick();
      t.start_req = 1'b1;
      t.opcode    = rtc3w_pkg::OPCODE_WRITE;
      send_tick(t);
      repeat (12) send_tick(random_tick());
      set_half_period(16'd5);
      finish_transfer();
   endtask

   task automatic test_random_traffic();
      set_half_period(16'd1);
      run_random(60);
      set_half_period(16'd2);
      run_random(60);
      set_half_period(16'd1);
      run_random(60);
      set_half_period(16'd3);
      run_random(60);
      set_half_period(16'($urandom_range(1, 6)));
      run_random(50);
      set_half_period(16'd1);
      run_random(60);
   endtask

   // The consumer holds off long enough for the block to fill and refuse request beats.
   task automatic test_output_backpressure();
      hold_request = 60;
      run_random(40);
      drain_responses();
   endtask

   task automatic test_steady_flow();
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      run_random(100);
      drain_responses();
   endtask

   initial begin : response_consumer
      int stall_left;
      int hold_left;
      bit ready_next;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 13);
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (pending_pin_levels.size() == 0) begin
            report_mismatch("unpredicted beat", 1, 0);
         end else begin
            wanted = pending_pin_levels.pop_front();
            if (rsp_chip_enable !== wanted.chip_enable)
               report_mismatch("chip_enable", rsp_chip_enable, wanted.chip_enable);
            if (rsp_serial_clock !== wanted.serial_clock)
               report_mismatch("serial_clock", rsp_serial_clock, wanted.serial_clock);
            if (rsp_io_out !== wanted.io_out)
               report_mismatch("io_out", rsp_io_out, wanted.io_out);
            if (rsp_io_drive !== wanted.io_drive)
               report_mismatch("io_drive", rsp_io_drive, wanted.io_drive);
            if (rsp_busy_res !== wanted.busy_res)
               report_mismatch("busy_res", rsp_busy_res, wanted.busy_res);
            if (rsp_done_res !== wanted.done_res)
               report_mismatch("done_res", rsp_done_res, wanted.done_res);
            if (rsp_read_byte !== wanted.read_byte)
               report_mismatch("read_byte", rsp_read_byte, wanted.read_byte);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles, %0d responses outstanding",
                  quiet_cycles, pending_pin_levels.size());
         $display("three_wire_rtc_byte_master test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_start_req         = 1'b0;
      req_opcode            = 1'b0;
      req_reg_address       = 6'd0;
      req_write_byte        = 8'd0;
      req_io_in             = 1'b0;
      rsp_ready             = 1'b0;
      csr_valid             = 1'b0;
      csr_half_period_ticks = 16'd0;
      half_period           = rtc3w_pkg::HALF_PERIOD_RESET;
      xfer_active           = 1'b0;
      xfer_is_read          = 1'b0;
      bit_index             = 5'd0;
      cmd_shift             = 8'd0;
      data_byte             = 8'd0;
      sampled_bits          = 8'd0;
      phase_ticks           = 16'd0;
      sclk_high             = 1'b0;
      ticks_sent            = 0;
      reads_done            = 0;
      writes_done           = 0;
      settings_used         = 0;
      mismatches            = 0;
      beats_checked         = 0;
      quiet_cycles          = 0;
      hold_request          = 0;
      sender_gaps           = 1'b1;
      receiver_stalls       = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_half_period();
      test_directed_transfers();
      test_half_period_changes();
      test_random_traffic();
      test_output_backpressure();
      test_steady_flow();
      repeat (8) @(posedge clock);

      $display("Covered %0d ticks: %0d reads and %0d writes finished over %0d half-period writes",
               ticks_sent, reads_done, writes_done, settings_used);
      $display("(0, 1 and 65535 among them), with random gaps and a long output hold-off.");
      if (mismatches == 0 && pending_pin_levels.size() == 0)
         $display("three_wire_rtc_byte_master test passed");
      else
         $display("three_wire_rtc_byte_master test failed");
      $finish;
   end

endmodule

/* files.f */
design/rtc3w_pkg.sv
design/rtc3w_core.sv
design/rtc3w_skid.sv
design/three_wire_rtc_byte_master.sv
tb/testbench.sv
